[hw/rtl/tlx_pkg.sv]
// Shared types, constants and helper functions of the token lexer.
// Used by every file of the block but tlx_if; depends on nothing.
`timescale 1ns / 1ps

package tlx_pkg;

  // Sizing of the lexer state.
  localparam int MAX_TOKEN_LEN = 255;
  localparam int LINE_BITS     = 16;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 2);
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);
  localparam int SLOTS         = 3;
  localparam int CFG_ADDR_W    = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_START_LINE = 3'd0;

  // Token kinds.
  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_PLUS    = 5'd1;
  localparam logic [4:0] K_MINUS   = 5'd2;
  localparam logic [4:0] K_LBRACK  = 5'd3;
  localparam logic [4:0] K_RBRACK  = 5'd4;
  localparam logic [4:0] K_LPAREN  = 5'd5;
  localparam logic [4:0] K_RPAREN  = 5'd6;
  localparam logic [4:0] K_LBRACE  = 5'd7;
  localparam logic [4:0] K_RBRACE  = 5'd8;
  localparam logic [4:0] K_FN      = 5'd9;
  localparam logic [4:0] K_IF      = 5'd10;
  localparam logic [4:0] K_ELSE    = 5'd11;
  localparam logic [4:0] K_INT     = 5'd12;
  localparam logic [4:0] K_FLOAT   = 5'd13;
  localparam logic [4:0] K_ID      = 5'd14;
  localparam logic [4:0] K_ASSIGN  = 5'd15;
  localparam logic [4:0] K_SEMI    = 5'd16;
  localparam logic [4:0] K_UNKNOWN = 5'd17;

  // Keyword spellings, first character in the low byte.
  localparam logic [31:0] KW_FN   = 32'h0000_6E66;
  localparam logic [31:0] KW_IF   = 32'h0000_6669;
  localparam logic [31:0] KW_ELSE = 32'h6573_6C65;

  // Scan modes.
  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_INT   = 5'b00010,
    M_FLOAT = 5'b00100,
    M_IDENT = 5'b01000,
    M_COLON = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [7:0]  len;
    logic [15:0] line;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t r;
  } cand_t;

  // All tokens caused by one input byte.
  typedef struct packed {
    result_t [SLOTS-1:0] item;
    logic [1:0]          cnt;
  } bundle_t;

  // Configuration write toward the front end.
  typedef struct packed {
    logic        wr;
    logic [15:0] value;
  } cfg_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return (c == "_") || is_alpha(c) || is_digit(c);
  endfunction

  // Kind of a single-character punctuation token, K_END when none.
  function automatic logic [4:0] punct_kind(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "[":     k = K_LBRACK;
      "]":     k = K_RBRACK;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      ";":     k = K_SEMI;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] fit8(logic [LEN_W-1:0] l);
    logic [LEN_W+7:0] w;
    w = {8'b0, l};
    return w[7:0];
  endfunction

  function automatic logic [15:0] fit16(logic [LINE_BITS-1:0] l);
    logic [LINE_BITS+15:0] w;
    w = {16'b0, l};
    return w[15:0];
  endfunction

  function automatic logic [LINE_BITS-1:0] fit_line(logic [15:0] s);
    logic [LINE_BITS+15:0] w;
    w = {{LINE_BITS{1'b0}}, s};
    return w[LINE_BITS-1:0];
  endfunction

  function automatic logic [4:0] ident_kind(logic [LEN_W-1:0] l, logic [31:0] p);
    logic [4:0] k;
    k = K_ID;
    if ((l == LEN_W'(2)) && (p == KW_FN)) k = K_FN;
    else if ((l == LEN_W'(2)) && (p == KW_IF)) k = K_IF;
    else if ((l == LEN_W'(4)) && (p == KW_ELSE)) k = K_ELSE;
    return k;
  endfunction

  // Token left pending in a scan mode; not valid in idle.
  function automatic cand_t flush_item(mode_t m, logic [31:0] s, logic [LEN_W-1:0] l,
                                       logic [31:0] p, logic [LINE_BITS-1:0] ln);
    cand_t c;
    logic [LEN_W-1:0] sh;
    sh = (l > LEN_W'(MAX_TOKEN_LEN)) ? LEN_W'(MAX_TOKEN_LEN) : l;
    c.valid   = 1'b1;
    c.r.start = s;
    c.r.len   = fit8(sh);
    c.r.line  = fit16(ln);
    unique case (m)
      M_INT:   c.r.kind = K_INT;
      M_FLOAT: c.r.kind = K_FLOAT;
      M_IDENT: c.r.kind = ident_kind(l, p);
      M_COLON: begin
        c.r.kind = K_UNKNOWN;
        c.r.len  = 8'd1;
      end
      default: begin
        c.valid  = 1'b0;
        c.r.kind = K_END;
      end
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/tlx_if.sv]
// Stream interfaces of the token lexer: source bytes in, tokens out.
// Depends on no other file.
`timescale 1ns / 1ps

interface tlx_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink (input valid, input char_in, input last_char, output ready);
endinterface

interface tlx_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] token_start;
  logic [7:0]  token_length;
  logic [15:0] token_line;
  logic        run_last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output token_line, output run_last,
                  input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input token_line, input run_last,
                output ready);
endinterface

[hw/rtl/tlx_front.sv]
// Front end of the token lexer: scan state, classification of each byte and
// packing of the tokens it causes into one bundle. Depends on tlx_pkg.
`timescale 1ns / 1ps

module tlx_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        char_in,
  input  logic              last_char,
  output logic              in_ready,
  input  logic              q_full,
  output logic              push,
  output tlx_pkg::bundle_t  push_data,
  input  tlx_pkg::cfg_t     cfg,
  output logic [15:0]       start_line
);
  import tlx_pkg::*;

  mode_t                 mode, mode_next;
  logic [31:0]           tok_start, tok_start_next;
  logic [LEN_W-1:0]      tok_len, tok_len_next;
  logic [31:0]           tok_prefix, tok_prefix_next;
  logic [31:0]           byte_pos, byte_pos_next;
  logic [LINE_BITS-1:0]  line_count, line_count_next;
  logic [LINE_BITS-1:0]  tok_line, tok_line_next;

  logic                  accept;
  logic                  used;
  logic [4:0]            pk;
  logic [LEN_W-1:0]      len_inc;
  logic [31:0]           prefix_ext;
  cand_t [3:0]           cand;
  logic [2:0]            n;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pk       = punct_kind(char_in);

  // Growing the current token by one byte.
  assign len_inc = (tok_len <= LEN_W'(MAX_TOKEN_LEN)) ? LEN_W'(tok_len + 1'b1) : tok_len;
  assign prefix_ext = (tok_len < LEN_W'(4)) ?
                      (tok_prefix | ({24'b0, char_in} << {tok_len[1:0], 3'b000})) :
                      tok_prefix;

  // Next scan state and the candidate tokens in emission order.
  always_comb begin
    mode_next       = mode;
    tok_start_next  = tok_start;
    tok_len_next    = tok_len;
    tok_prefix_next = tok_prefix;
    tok_line_next   = tok_line;
    line_count_next = line_count;
    used            = 1'b0;
    cand            = '0;

    // Continue or close the pending token.
    unique case (mode)
      M_INT: begin
        if (is_digit(char_in)) begin
          tok_len_next    = len_inc;
          tok_prefix_next = prefix_ext;
          used            = 1'b1;
        end else if (char_in == ".") begin
          tok_len_next    = len_inc;
          tok_prefix_next = prefix_ext;
          mode_next       = M_FLOAT;
          used            = 1'b1;
        end else begin
          cand[0]   = flush_item(mode, tok_start, tok_len, tok_prefix, tok_line);
          mode_next = M_IDLE;
        end
      end
      M_FLOAT: begin
        if (is_digit(char_in)) begin
          tok_len_next    = len_inc;
          tok_prefix_next = prefix_ext;
          used            = 1'b1;
        end else begin
          cand[0]   = flush_item(mode, tok_start, tok_len, tok_prefix, tok_line);
          mode_next = M_IDLE;
        end
      end
      M_IDENT: begin
        if (is_word(char_in)) begin
          tok_len_next    = len_inc;
          tok_prefix_next = prefix_ext;
          used            = 1'b1;
        end else begin
          cand[0]   = flush_item(mode, tok_start, tok_len, tok_prefix, tok_line);
          mode_next = M_IDLE;
        end
      end
      M_COLON: begin
        if (char_in == "=") begin
          cand[0].valid   = 1'b1;
          cand[0].r.kind  = K_ASSIGN;
          cand[0].r.start = tok_start;
          cand[0].r.len   = 8'd2;
          cand[0].r.line  = fit16(tok_line);
          used            = 1'b1;
        end else begin
          cand[0] = flush_item(mode, tok_start, tok_len, tok_prefix, tok_line);
        end
        mode_next = M_IDLE;
      end
      default: mode_next = M_IDLE;
    endcase

    // A byte not taken by the pending token starts something of its own.
    if (!used) begin
      priority if ((char_in == " ") || (char_in == "\t")) begin
        // Separator only.
      end else if (char_in == "\n") begin
        line_count_next = line_count + 1'b1;
      end else if (pk != K_END) begin
        cand[1].valid   = 1'b1;
        cand[1].r.kind  = pk;
        cand[1].r.start = byte_pos;
        cand[1].r.len   = 8'd1;
        cand[1].r.line  = fit16(line_count);
      end else if (is_digit(char_in) || (char_in == "_") || is_alpha(char_in) ||
                   (char_in == ":")) begin
        if (is_digit(char_in)) mode_next = M_INT;
        else if (char_in == ":") mode_next = M_COLON;
        else mode_next = M_IDENT;
        tok_start_next  = byte_pos;
        tok_len_next    = LEN_W'(1);
        tok_prefix_next = {24'b0, char_in};
        tok_line_next   = line_count;
      end else begin
        cand[1].valid   = 1'b1;
        cand[1].r.kind  = K_UNKNOWN;
        cand[1].r.start = byte_pos;
        cand[1].r.len   = 8'd1;
        cand[1].r.line  = fit16(line_count);
      end
    end

    byte_pos_next = byte_pos + 32'd1;

    // The final byte flushes, ends the text and rewinds for the next one.
    if (last_char) begin
      cand[2] = flush_item(mode_next, tok_start_next, tok_len_next, tok_prefix_next,
                           tok_line_next);
      cand[3].valid   = 1'b1;
      cand[3].r.kind  = K_END;
      cand[3].r.start = byte_pos_next;
      cand[3].r.len   = 8'd0;
      cand[3].r.line  = fit16(line_count_next);
      byte_pos_next   = 32'd0;
      line_count_next = fit_line(start_line);
      mode_next       = M_IDLE;
    end
  end

  // Pack the valid candidates into the bundle slots.
  always_comb begin
    n         = 3'd0;
    push_data = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand[i].valid && (n < 3'(SLOTS))) begin
        push_data.item[n[1:0]] = cand[i].r;
        n = n + 3'd1;
      end
    end
    push_data.cnt = n[1:0];
  end

  assign push = accept && (n != 3'd0);

  // State registers and the start-line register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      tok_start  <= 32'd0;
      tok_len    <= '0;
      tok_prefix <= 32'd0;
      byte_pos   <= 32'd0;
      line_count <= fit_line(16'd1);
      tok_line   <= '0;
      start_line <= 16'd1;
    end else begin
      if (accept) begin
        mode       <= mode_next;
        tok_start  <= tok_start_next;
        tok_len    <= tok_len_next;
        tok_prefix <= tok_prefix_next;
        byte_pos   <= byte_pos_next;
        tok_line   <= tok_line_next;
      end
      if (cfg.wr) start_line <= cfg.value;
      // A start-line write at the start of a text also reloads the line count.
      if (cfg.wr && (byte_pos == 32'd0)) begin
        line_count <= fit_line(cfg.value);
      end else if (accept) begin
        line_count <= line_count_next;
      end
    end
  end

endmodule

[hw/rtl/tlx_queue.sv]
// Short queue of token bundles between the front and back ends.
// Depends on tlx_pkg.
`timescale 1ns / 1ps

module tlx_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tlx_pkg::bundle_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tlx_pkg::bundle_t  head
);
  import tlx_pkg::*;

  bundle_t             entry [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entry[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/tlx_back.sv]
// Back end of the token lexer: hands out the tokens of the head bundle one
// transfer at a time and marks the last one. Depends on tlx_pkg.
`timescale 1ns / 1ps

module tlx_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  tlx_pkg::bundle_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output tlx_pkg::result_t  out_item,
  output logic              out_last
);
  import tlx_pkg::*;

  logic [1:0] idx;
  logic       xfer;

  assign out_valid = head_valid;
  assign out_item  = head.item[idx];
  assign out_last  = (idx == (head.cnt - 2'd1));
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && out_last;

  // Slot counter within the head bundle.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (xfer) begin
      idx <= out_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

[hw/rtl/token_lexer_unit.sv]
// Top level of the token lexer: byte and token channels, configuration port,
// front end, bundle queue and back end. Depends on tlx_pkg, tlx_if and submodules.
//
//   channel   direction  payload                                       transfer
//   chars     in         char_in[7:0], last_char                       valid & ready
//   tokens    out        token_kind, token_start, token_length,        valid & ready
//                        token_line, run_last
//   apb       in/out     start_line register at address 0              psel & penable
//
// One byte is taken in each cycle while the bundle queue (four bundles) has
// room; the tokens that one byte causes leave the token channel one per
// transfer, in the order of the bundle slots.
// Tokens leave straight from the queue storage, so byte intake and token
// delivery stall independently. Reset is synchronous, active high, and
// needs no clearing pass; start_line resets to 1.
`timescale 1ns / 1ps

module token_lexer_unit (
  input  logic                                clk,
  input  logic                                rst,
  tlx_char_if.sink                            chars,
  tlx_token_if.source                         tokens,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tlx_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import tlx_pkg::*;

  cfg_t        cfg;
  logic [15:0] start_line;
  logic        q_full, push, pop, head_valid;
  bundle_t     push_data, head;
  result_t     out_item;
  logic        hit;

  // Register decode; the two low address bits are the byte offset.
  assign hit       = ({paddr[CFG_ADDR_W-1:2], 2'b00} == REG_START_LINE);
  assign pready    = 1'b1;
  assign cfg.wr    = psel && penable && pwrite && hit;
  assign cfg.value = pwdata[15:0];
  assign prdata    = hit ? {16'b0, start_line} : 32'd0;

  tlx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chars.valid),
    .char_in    (chars.char_in),
    .last_char  (chars.last_char),
    .in_ready   (chars.ready),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data),
    .cfg        (cfg),
    .start_line (start_line)
  );

  tlx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tlx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (tokens.valid),
    .out_ready  (tokens.ready),
    .out_item   (out_item),
    .out_last   (tokens.run_last)
  );

  // Token payload onto the output channel.
  assign tokens.token_kind   = out_item.kind;
  assign tokens.token_start  = out_item.start;
  assign tokens.token_length = out_item.len;
  assign tokens.token_line   = out_item.line;

endmodule
